>>> sv/lsra_pkg.sv
// Shared types and constants of the linear-scan register allocator.
`timescale 1ns / 1ps
`default_nettype none

package lsra_pkg;

    // Number of physical registers that can be handed out.
    localparam int unsigned NUM_REGS  = 64;
    // Width of a register number.
    localparam int unsigned REG_W     = $clog2(NUM_REGS);
    // Width of a count that can reach NUM_REGS itself.
    localparam int unsigned CNT_W     = $clog2(NUM_REGS + 1);
    // Width of an instruction index (signed).
    localparam int unsigned PT_W      = 11;
    // Width of the register number in a result.
    localparam int unsigned OUT_IDX_W = 6;
    // Stream data widths, padded to whole bytes.
    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned M_TDATA_W = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RETIRE,
        ST_COMMIT
    } state_t;

    typedef enum logic [1:0] {
        ALLOC_POP,
        ALLOC_FRESH,
        ALLOC_FAIL
    } alloc_t;

    typedef struct packed {
        logic   load;
        logic   retire;
        logic   commit;
        alloc_t alloc;
    } dp_cmd_t;

    typedef struct packed {
        logic head_expired;
        logic stack_empty;
        logic all_opened;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

>>> sv/lsra_ctrl.sv
// Controller state machine of the linear-scan register allocator.
`timescale 1ns / 1ps
`default_nettype none

module lsra_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire lsra_pkg::dp_status_t status,
    output lsra_pkg::dp_cmd_t         cmd
);

    lsra_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lsra_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.alloc  = lsra_pkg::ALLOC_POP;
        unique case (state_reg)
            lsra_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = lsra_pkg::ST_RETIRE;
                end
            end
            lsra_pkg::ST_RETIRE: begin
                // Expired entries form a prefix of the sorted list.
                if (status.head_expired) begin
                    cmd.retire = 1'b1;
                end else begin
                    state_next = lsra_pkg::ST_COMMIT;
                end
            end
            lsra_pkg::ST_COMMIT: begin
                if (!status.stack_empty) begin
                    cmd.alloc = lsra_pkg::ALLOC_POP;
                end else if (!status.all_opened) begin
                    cmd.alloc = lsra_pkg::ALLOC_FRESH;
                end else begin
                    cmd.alloc = lsra_pkg::ALLOC_FAIL;
                end
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = lsra_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lsra_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/lsra_dp.sv
// Datapath of the linear-scan register allocator: active list, free stack, counts, result.
`timescale 1ns / 1ps
`default_nettype none

module lsra_dp (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire lsra_pkg::dp_cmd_t                  cmd,
    output lsra_pkg::dp_status_t                    status,
    input  wire logic [lsra_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire logic [0:0]                         s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [lsra_pkg::M_TDATA_W-1:0]          m_tdata,
    output logic [1:0]                              m_tuser
);

    localparam int unsigned NR = lsra_pkg::NUM_REGS;
    localparam int unsigned RW = lsra_pkg::REG_W;
    localparam int unsigned CW = lsra_pkg::CNT_W;
    localparam int unsigned PW = lsra_pkg::PT_W;
    localparam int unsigned OW = lsra_pkg::OUT_IDX_W;

    logic signed [PW-1:0] start_reg, end_reg;

    // Active list as a row of cells, kept sorted by last read.
    logic signed [PW-1:0] cell_end_reg [NR];
    logic [RW-1:0]        cell_id_reg  [NR];

    logic [CW-1:0] active_cnt_reg, free_cnt_reg, opened_cnt_reg;

    logic [RW-1:0] stack_mem [NR];
    logic [RW-1:0] stack_rd_reg;
    logic [RW-1:0] stack_rd_addr;

    logic          m_valid_reg;
    logic [OW-1:0] m_idx_reg;
    logic          m_fresh_reg;
    logic          m_oor_reg;

    logic          push_ok;
    logic          ins_ok;
    logic [RW-1:0] new_id;
    logic [NR-1:0] place;
    logic [OW+RW-1:0] id_ext;

    assign push_ok       = free_cnt_reg < CW'(NR);
    assign stack_rd_addr = RW'(free_cnt_reg - 1'b1);
    assign new_id        = (cmd.alloc == lsra_pkg::ALLOC_POP) ? stack_rd_reg
                                                               : opened_cnt_reg[RW-1:0];
    assign ins_ok        = cmd.commit && (cmd.alloc != lsra_pkg::ALLOC_FAIL)
                           && (active_cnt_reg < CW'(NR));
    assign id_ext        = {{OW{1'b0}}, new_id};

    // place[i] marks the cells from the insertion point up to the first empty cell (a run of ones).
    always_comb begin
        for (int i = 0; i < NR; i++) begin
            if (CW'(i) < active_cnt_reg) begin
                place[i] = cell_end_reg[i] > end_reg;
            end else begin
                place[i] = (CW'(i) == active_cnt_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            start_reg <= $signed(s_tdata[PW-1:0]);
            end_reg   <= $signed(s_tdata[2*PW-1:PW]);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.retire) begin
            for (int i = 0; i < NR - 1; i++) begin
                cell_end_reg[i] <= cell_end_reg[i+1];
                cell_id_reg[i]  <= cell_id_reg[i+1];
            end
        end else if (ins_ok) begin
            if (place[0]) begin
                cell_end_reg[0] <= end_reg;
                cell_id_reg[0]  <= new_id;
            end
            for (int i = 1; i < NR; i++) begin
                if (place[i-1]) begin
                    cell_end_reg[i] <= cell_end_reg[i-1];
                    cell_id_reg[i]  <= cell_id_reg[i-1];
                end else if (place[i]) begin
                    cell_end_reg[i] <= end_reg;
                    cell_id_reg[i]  <= new_id;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.retire && push_ok) begin
            stack_mem[free_cnt_reg[RW-1:0]] <= cell_id_reg[0];
        end
        stack_rd_reg <= stack_mem[stack_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_cnt_reg <= '0;
            free_cnt_reg   <= '0;
            opened_cnt_reg <= '0;
        end else if (cmd.load) begin
            if (s_tuser[0]) begin
                active_cnt_reg <= '0;
                free_cnt_reg   <= '0;
                opened_cnt_reg <= '0;
            end
        end else if (cmd.retire) begin
            active_cnt_reg <= active_cnt_reg - 1'b1;
            if (push_ok) begin
                free_cnt_reg <= free_cnt_reg + 1'b1;
            end
        end else if (cmd.commit) begin
            case (cmd.alloc)
                lsra_pkg::ALLOC_POP:   free_cnt_reg   <= free_cnt_reg - 1'b1;
                lsra_pkg::ALLOC_FRESH: opened_cnt_reg <= opened_cnt_reg + 1'b1;
                default: ;
            endcase
            if (ins_ok) begin
                active_cnt_reg <= active_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            if (cmd.alloc == lsra_pkg::ALLOC_FAIL) begin
                m_idx_reg   <= '0;
                m_fresh_reg <= 1'b0;
                m_oor_reg   <= 1'b1;
            end else begin
                m_idx_reg   <= id_ext[OW-1:0];
                m_fresh_reg <= (cmd.alloc == lsra_pkg::ALLOC_FRESH);
                m_oor_reg   <= 1'b0;
            end
        end
    end

    assign status.head_expired = (active_cnt_reg != '0) && (cell_end_reg[0] <= start_reg);
    assign status.stack_empty  = (free_cnt_reg == '0);
    assign status.all_opened   = (opened_cnt_reg == CW'(NR));
    assign status.out_free     = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(lsra_pkg::M_TDATA_W - OW){1'b0}}, m_idx_reg};
    assign m_tuser  = {m_oor_reg, m_fresh_reg};

endmodule

`default_nettype wire

>>> sv/linear_scan_register_allocator.sv
// Top level of the linear-scan register allocator.
//
//  Channel | Direction | Data                                   | Side band
//  --------+-----------+----------------------------------------+---------------------------
//  s_      | in        | start_point [10:0], end_point [21:11]  | tuser[0] new_pass
//  m_      | out       | register_index [5:0]                   | tuser[0] fresh, [1] oor
//
// For each item, the idle state takes the request, the retirement loop retires one expired
// active entry per cycle and settles the free-stack read when it leaves, and the commit
// state assigns, inserts and posts the result. Each interval is retired at most once.
// Reset (aresetn low, synchronous) empties the active list, the free stack and the
// opened count at once; no clearing pass is needed. A stalled result sits in the output
// register while the next request is taken; only the assignment cycle waits for it.
`timescale 1ns / 1ps
`default_nettype none

module linear_scan_register_allocator (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Input requests: tdata = start_point [10:0], end_point [21:11], zeros [23:22].
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [lsra_pkg::S_TDATA_W-1:0]  s_tdata,
    // tuser = new_pass [0].
    input  wire logic [0:0]                      s_tuser,
    // Results: tdata = register_index [5:0], zeros [7:6].
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [lsra_pkg::M_TDATA_W-1:0]       m_tdata,
    // tuser = fresh_register [0], out_of_registers [1].
    output logic [1:0]                           m_tuser
);

    lsra_pkg::dp_cmd_t    cmd;
    lsra_pkg::dp_status_t status;

    // The controller sequences each request: accept, retire the expired prefix of
    // the active list one entry per cycle, then pick a register and commit.
    lsra_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the sorted active list as a row of cells, the free stack
    // as a small memory with a registered read port, the counts and the result register.
    lsra_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
